// ----- sv/segment_pair_distance_intersect_core_assert.svh -----
// Assertion macros for the segment pair distance and crossing core
`ifndef SEGMENT_PAIR_DISTANCE_INTERSECT_CORE_ASSERT_SVH
`define SEGMENT_PAIR_DISTANCE_INTERSECT_CORE_ASSERT_SVH

// Same-cycle implication
`define SPDI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spdi assertion failed");

// Next-cycle implication
`define SPDI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spdi assertion failed");

`endif

// ----- sv/spdi_pkg.sv -----
// Types, widths and helper functions shared by the segment pair core
`timescale 1ns / 1ps
package spdi_pkg;

    localparam int COORD_BITS      = 24;
    localparam int DIST_BITS       = 52;
    localparam int DIFF_W          = COORD_BITS + 1;
    localparam int PROD_W          = 2 * DIFF_W;
    localparam int SUM_W           = PROD_W + 1;
    localparam int HALF_W          = (SUM_W + 1) / 2;
    localparam int PART_W          = HALF_W + DIFF_W;
    localparam int NUM_W           = SUM_W + DIFF_W + 2;
    localparam int DEN_W           = SUM_W + 1;
    localparam int QUO_W           = DIFF_W;
    localparam int VEC_W           = DIFF_W + 1;
    localparam int SQ_W            = 2 * VEC_W;
    localparam int SSUM_W          = SQ_W + 1;
    localparam int SLOTS           = 4;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    localparam logic [1:0] MODE_END_A = 2'd0;
    localparam logic [1:0] MODE_END_B = 2'd1;
    localparam logic [1:0] MODE_PROJ  = 2'd2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [SUM_W-1:0]      sum_t;

    typedef struct packed {
        diff_t x;
        diff_t y;
    } dvec_t;

    typedef struct packed {
        prod_t p;
        prod_t q;
    } ppair_t;

    typedef struct packed {
        coord_t p1_x;
        coord_t p1_y;
        coord_t p2_x;
        coord_t p2_y;
        coord_t q1_x;
        coord_t q1_y;
        coord_t q2_x;
        coord_t q2_y;
    } spdi_in_t;

    typedef struct packed {
        logic [DIST_BITS-1:0] dist_squared;
        logic                 crossing;
        coord_t               cross_x;
        coord_t               cross_y;
    } spdi_out_t;

    typedef struct packed {
        sum_t  dot;
        sum_t  len2;
        dvec_t ab;
        dvec_t ap;
        sum_t  end_a;
        sum_t  end_b;
    } spdi_slot_t;

    typedef struct packed {
        logic                         crossing;
        coord_t                       p1_x;
        coord_t                       p1_y;
        dvec_t                        r;
        sum_t                         num;
        sum_t                         den;
        spdi_slot_t [SLOTS-1:0]       slot;
    } spdi_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } spdi_q_stat_t;

    function automatic dvec_t dsub(coord_t ax, coord_t ay, coord_t bx, coord_t by);
        dvec_t r;
        r.x = diff_t'(ax) - diff_t'(bx);
        r.y = diff_t'(ay) - diff_t'(by);
        return r;
    endfunction

    function automatic dvec_t dneg(dvec_t v);
        dvec_t r;
        r.x = -v.x;
        r.y = -v.y;
        return r;
    endfunction

    function automatic ppair_t mk_cross(dvec_t u, dvec_t v);
        ppair_t r;
        r.p = u.x * v.y;
        r.q = u.y * v.x;
        return r;
    endfunction

    function automatic ppair_t mk_dot(dvec_t u, dvec_t v);
        ppair_t r;
        r.p = u.x * v.x;
        r.q = u.y * v.y;
        return r;
    endfunction

    function automatic sum_t pp_sub(ppair_t v);
        return sum_t'(v.p) - sum_t'(v.q);
    endfunction

    function automatic sum_t pp_add(ppair_t v);
        return sum_t'(v.p) + sum_t'(v.q);
    endfunction

    function automatic logic [SUM_W-1:0] mag_sum(sum_t v);
        return v[SUM_W-1] ? $unsigned(-v) : $unsigned(v);
    endfunction

    function automatic logic [DIFF_W-1:0] mag_diff(diff_t v);
        return v[DIFF_W-1] ? $unsigned(-v) : $unsigned(v);
    endfunction

    function automatic logic [DIST_BITS-1:0] sat_dist(logic [SSUM_W-1:0] v);
        return (|v[SSUM_W-1:DIST_BITS]) ? DIST_MAX : v[DIST_BITS-1:0];
    endfunction

    function automatic coord_t clamp_coord(logic signed [COORD_BITS+1:0] v);
        coord_t r;
        if (v[COORD_BITS+1:COORD_BITS-1] == 3'b000 || v[COORD_BITS+1:COORD_BITS-1] == 3'b111)
        begin
            r = v[COORD_BITS-1:0];
        end
        else if (v[COORD_BITS+1])
        begin
            r = {1'b1, {(COORD_BITS-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(COORD_BITS-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ----- sv/segment_pair_distance_intersect_core.sv -----
// Top level of the segment pair distance and crossing core
`timescale 1ns / 1ps
// Accepts one segment pair per clock while the job queue has room, and returns one result per
// pair, in order. The back part uses pipelined restoring dividers, which resolve one quotient
// bit per stage. A stall on the result side holds the back pipeline; the job queue lets the
// front keep accepting until it fills.
module segment_pair_distance_intersect_core
    import spdi_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  spdi_in_t  req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output spdi_out_t rsp
);

`include "segment_pair_distance_intersect_core_assert.svh"

    logic         job_valid;
    spdi_job_t    job;
    spdi_job_t    q_data;
    spdi_q_stat_t q_stat;
    logic         pop;

    spdi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .job_valid (job_valid),
        .job       (job),
        .stat      (q_stat)
    );

    spdi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (job_valid),
        .push_data  (job),
        .pop        (pop),
        .pop_data   (q_data),
        .stat       (q_stat)
    );

    spdi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!q_stat.empty),
        .job       (q_data),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    `SPDI_ASSERT_IMP(a_cross_zero_dist, clk, rst_n, rsp_valid && rsp.crossing, rsp.dist_squared == '0)
    `SPDI_ASSERT_IMP(a_nocross_zero_pt, clk, rst_n, rsp_valid && !rsp.crossing, rsp.cross_x == '0 && rsp.cross_y == '0)
    `SPDI_ASSERT_IMP(a_queue_flags, clk, rst_n, q_stat.full, !q_stat.empty)
    `SPDI_ASSERT_NXT(a_full_stall, clk, rst_n, job_valid && q_stat.full && !pop, !req_ready)

endmodule

// ----- sv/spdi_front.sv -----
// Front part: takes segment pairs, forms cross products and dots, classifies crossing
`timescale 1ns / 1ps
module spdi_front
    import spdi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_ready,
    input  spdi_in_t     req,
    output logic         job_valid,
    output spdi_job_t    job,
    input  spdi_q_stat_t stat
);

    typedef struct packed {
        dvec_t r;
        dvec_t s;
        dvec_t a;
        dvec_t b;
        dvec_t c;
        dvec_t e;
        coord_t p1_x;
        coord_t p1_y;
    } diffs_t;

    typedef struct packed {
        ppair_t c_ra;
        ppair_t c_rb;
        ppair_t c_sc;
        ppair_t c_as;
        ppair_t c_rs;
        ppair_t l_r;
        ppair_t l_s;
        ppair_t d_as;
        ppair_t d_cs;
        ppair_t d_ar;
        ppair_t d_br;
        ppair_t q_a;
        ppair_t q_b;
        ppair_t q_c;
        ppair_t q_e;
    } prods_t;

    logic      adv;
    logic      f1_v_reg;
    logic      f2_v_reg;
    logic      f3_v_reg;
    diffs_t    f1_reg;
    diffs_t    f2_d_reg;
    prods_t    f2_p_reg;
    spdi_job_t f3_reg;
    diffs_t    f1_next;
    prods_t    f2_next;
    spdi_job_t f3_next;

    assign adv       = !(f3_v_reg && stat.full);
    assign req_ready = adv;
    assign job_valid = f3_v_reg;
    assign job       = f3_reg;

    always_comb
    begin
        f1_next.r    = dsub(req.p2_x, req.p2_y, req.p1_x, req.p1_y);
        f1_next.s    = dsub(req.q2_x, req.q2_y, req.q1_x, req.q1_y);
        f1_next.a    = dsub(req.q1_x, req.q1_y, req.p1_x, req.p1_y);
        f1_next.b    = dsub(req.q2_x, req.q2_y, req.p1_x, req.p1_y);
        f1_next.c    = dsub(req.p2_x, req.p2_y, req.q1_x, req.q1_y);
        f1_next.e    = dsub(req.p2_x, req.p2_y, req.q2_x, req.q2_y);
        f1_next.p1_x = req.p1_x;
        f1_next.p1_y = req.p1_y;
    end

    always_comb
    begin
        f2_next.c_ra = mk_cross(f1_reg.r, f1_reg.a);
        f2_next.c_rb = mk_cross(f1_reg.r, f1_reg.b);
        f2_next.c_sc = mk_cross(f1_reg.s, f1_reg.c);
        f2_next.c_as = mk_cross(f1_reg.a, f1_reg.s);
        f2_next.c_rs = mk_cross(f1_reg.r, f1_reg.s);
        f2_next.l_r  = mk_dot(f1_reg.r, f1_reg.r);
        f2_next.l_s  = mk_dot(f1_reg.s, f1_reg.s);
        f2_next.d_as = mk_dot(f1_reg.a, f1_reg.s);
        f2_next.d_cs = mk_dot(f1_reg.c, f1_reg.s);
        f2_next.d_ar = mk_dot(f1_reg.a, f1_reg.r);
        f2_next.d_br = mk_dot(f1_reg.b, f1_reg.r);
        f2_next.q_a  = mk_dot(f1_reg.a, f1_reg.a);
        f2_next.q_b  = mk_dot(f1_reg.b, f1_reg.b);
        f2_next.q_c  = mk_dot(f1_reg.c, f1_reg.c);
        f2_next.q_e  = mk_dot(f1_reg.e, f1_reg.e);
    end

    always_comb
    begin
        sum_t c1;
        sum_t c2;
        sum_t c4;
        sum_t num;
        sum_t ls;
        sum_t lr;
        sum_t qa;
        sum_t qb;
        sum_t qc;
        sum_t qe;
        logic opp_p;
        logic opp_q;
        c1  = pp_sub(f2_p_reg.c_ra);
        c2  = pp_sub(f2_p_reg.c_rb);
        c4  = pp_sub(f2_p_reg.c_sc);
        num = pp_sub(f2_p_reg.c_as);
        ls  = pp_add(f2_p_reg.l_s);
        lr  = pp_add(f2_p_reg.l_r);
        qa  = pp_add(f2_p_reg.q_a);
        qb  = pp_add(f2_p_reg.q_b);
        qc  = pp_add(f2_p_reg.q_c);
        qe  = pp_add(f2_p_reg.q_e);
        opp_p = (c1[SUM_W-1] && !c2[SUM_W-1] && (|c2))
             || (c2[SUM_W-1] && !c1[SUM_W-1] && (|c1));
        opp_q = (num[SUM_W-1] && !c4[SUM_W-1] && (|c4))
             || (c4[SUM_W-1] && !num[SUM_W-1] && (|num));

        f3_next.crossing = opp_p && opp_q;
        f3_next.p1_x     = f2_d_reg.p1_x;
        f3_next.p1_y     = f2_d_reg.p1_y;
        f3_next.r        = f2_d_reg.r;
        f3_next.num      = num;
        f3_next.den      = pp_sub(f2_p_reg.c_rs);

        f3_next.slot[0].dot   = -pp_add(f2_p_reg.d_as);
        f3_next.slot[0].len2  = ls;
        f3_next.slot[0].ab    = f2_d_reg.s;
        f3_next.slot[0].ap    = dneg(f2_d_reg.a);
        f3_next.slot[0].end_a = qa;
        f3_next.slot[0].end_b = qb;

        f3_next.slot[1].dot   = pp_add(f2_p_reg.d_cs);
        f3_next.slot[1].len2  = ls;
        f3_next.slot[1].ab    = f2_d_reg.s;
        f3_next.slot[1].ap    = f2_d_reg.c;
        f3_next.slot[1].end_a = qc;
        f3_next.slot[1].end_b = qe;

        f3_next.slot[2].dot   = pp_add(f2_p_reg.d_ar);
        f3_next.slot[2].len2  = lr;
        f3_next.slot[2].ab    = f2_d_reg.r;
        f3_next.slot[2].ap    = f2_d_reg.a;
        f3_next.slot[2].end_a = qa;
        f3_next.slot[2].end_b = qc;

        f3_next.slot[3].dot   = pp_add(f2_p_reg.d_br);
        f3_next.slot[3].len2  = lr;
        f3_next.slot[3].ab    = f2_d_reg.r;
        f3_next.slot[3].ap    = f2_d_reg.b;
        f3_next.slot[3].end_a = qb;
        f3_next.slot[3].end_b = qe;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_v_reg <= req_valid;
            f2_v_reg <= f1_v_reg;
            f3_v_reg <= f2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_reg   <= f1_next;
            f2_d_reg <= f1_reg;
            f2_p_reg <= f2_next;
            f3_reg   <= f3_next;
        end
    end

endmodule

// ----- sv/spdi_queue.sv -----
// Short queue of classified jobs between the front and back parts
`timescale 1ns / 1ps
module spdi_queue
    import spdi_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    input  spdi_job_t    push_data,
    input  logic         pop,
    output spdi_job_t    pop_data,
    output spdi_q_stat_t stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    spdi_job_t       mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW:0]     count_reg;
    logic            do_push;
    logic            do_pop;

    assign stat.full  = (count_reg == (AW + 1)'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push_valid && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = mem_reg[rd_ptr_reg];

    function automatic logic [AW-1:0] bump(logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- sv/spdi_div.sv -----
// Pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module spdi_div
#(
    parameter int NUM_W = 78,
    parameter int DEN_W = 52,
    parameter int QUO_W = 25
)
(
    input  logic             clk,
    input  logic             adv,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    logic [NUM_W-1:0] rem_reg [QUO_W-1];
    logic [DEN_W-1:0] den_reg [QUO_W-1];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    assign quo = quo_reg[QUO_W-1];

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        localparam int SH = QUO_W - 1 - k;
        logic [NUM_W-1:0] rin;
        logic [DEN_W-1:0] din;
        logic [QUO_W-1:0] qin;
        logic [NUM_W-1:0] dsh;
        logic [NUM_W:0]   dif;
        logic [QUO_W-1:0] qout;

        if (k == 0)
        begin : g_first
            assign rin = num;
            assign din = den;
            assign qin = '0;
        end
        else
        begin : g_rest
            assign rin = rem_reg[k-1];
            assign din = den_reg[k-1];
            assign qin = quo_reg[k-1];
        end

        assign dsh = NUM_W'(din) << SH;
        assign dif = {1'b0, rin} - {1'b0, dsh};

        always_comb
        begin
            qout     = qin;
            qout[SH] = !dif[NUM_W];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                quo_reg[k] <= qout;
            end
        end

        if (k < QUO_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k] <= dif[NUM_W] ? rin : dif[NUM_W-1:0];
                    den_reg[k] <= din;
                end
            end
        end
    end

endmodule

// ----- sv/spdi_back.sv -----
// Back part: projections, divisions, squared distances, minimum and crossing point
`timescale 1ns / 1ps
module spdi_back
    import spdi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    input  spdi_job_t job,
    output logic      pop,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output spdi_out_t rsp
);

    localparam int VLEN = QUO_W + 7;

    typedef struct packed {
        dvec_t      ap;
        sum_t       end_a;
        sum_t       end_b;
        logic [1:0] mode;
        logic       neg_x;
        logic       neg_y;
    } bslot_t;

    typedef struct packed {
        logic                 crossing;
        coord_t               p1_x;
        coord_t               p1_y;
        bslot_t [SLOTS-1:0]   s;
    } side_t;

    logic              adv;
    logic [VLEN-1:0]   v_reg;
    logic              rsp_valid_reg;
    spdi_out_t         rsp_reg;

    side_t             k1_side_next;
    side_t             k1_side_reg;
    side_t             k2_side_reg;
    side_t             k3_side_reg;
    side_t             dly_reg [QUO_W];
    side_t             k4_side_reg;
    side_t             k5_side_reg;

    logic [SUM_W-1:0]  dmag_next [SLOTS];
    logic [SUM_W-1:0]  lmag_next [SLOTS];
    logic [DIFF_W-1:0] abx_next  [SLOTS];
    logic [DIFF_W-1:0] aby_next  [SLOTS];

    logic [SUM_W-1:0]  k1_dmag_reg [SLOTS];
    logic [SUM_W-1:0]  k1_lmag_reg [SLOTS];
    logic [DIFF_W-1:0] k1_abx_reg  [SLOTS];
    logic [DIFF_W-1:0] k1_aby_reg  [SLOTS];

    logic [PART_W-1:0] k2_plx_reg [SLOTS];
    logic [PART_W-1:0] k2_phx_reg [SLOTS];
    logic [PART_W-1:0] k2_ply_reg [SLOTS];
    logic [PART_W-1:0] k2_phy_reg [SLOTS];
    logic [SUM_W-1:0]  k2_lmag_reg [SLOTS];

    logic [NUM_W-1:0]  k3_nx_reg [SLOTS];
    logic [NUM_W-1:0]  k3_ny_reg [SLOTS];
    logic [DEN_W-1:0]  k3_d_reg  [SLOTS];

    logic [QUO_W-1:0]  quo_x [SLOTS];
    logic [QUO_W-1:0]  quo_y [SLOTS];

    logic signed [VEC_W-1:0] vx_next [SLOTS];
    logic signed [VEC_W-1:0] vy_next [SLOTS];
    logic signed [VEC_W-1:0] k4_vx_reg [SLOTS];
    logic signed [VEC_W-1:0] k4_vy_reg [SLOTS];
    coord_t                  cx_next;
    coord_t                  cy_next;
    coord_t                  k4_cx_reg;
    coord_t                  k4_cy_reg;
    coord_t                  k5_cx_reg;
    coord_t                  k5_cy_reg;
    coord_t                  k6_cx_reg;
    coord_t                  k6_cy_reg;
    coord_t                  k7_cx_reg;
    coord_t                  k7_cy_reg;

    logic signed [SQ_W-1:0]  k5_sqx_reg [SLOTS];
    logic signed [SQ_W-1:0]  k5_sqy_reg [SLOTS];

    logic [DIST_BITS-1:0]    dist_next [SLOTS];
    logic [DIST_BITS-1:0]    k6_dist_reg [SLOTS];
    logic                    k6_cross_reg;
    logic [DIST_BITS-1:0]    k7_m01_reg;
    logic [DIST_BITS-1:0]    k7_m23_reg;
    logic                    k7_cross_reg;
    spdi_out_t               rsp_next;

    assign adv       = !rsp_valid_reg || rsp_ready;
    assign pop       = adv;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        k1_side_next.crossing = job.crossing;
        k1_side_next.p1_x     = job.p1_x;
        k1_side_next.p1_y     = job.p1_y;
        for (int i = 0; i < SLOTS; i++)
        begin
            sum_t  dot;
            sum_t  len;
            dvec_t ab;
            dot = job.slot[i].dot;
            len = job.slot[i].len2;
            ab  = job.slot[i].ab;
            if (job.crossing && i == 0)
            begin
                dot = job.num;
                len = job.den;
                ab  = job.r;
            end
            k1_side_next.s[i].ap    = job.slot[i].ap;
            k1_side_next.s[i].end_a = job.slot[i].end_a;
            k1_side_next.s[i].end_b = job.slot[i].end_b;
            k1_side_next.s[i].neg_x = dot[SUM_W-1] ^ ab.x[DIFF_W-1] ^ len[SUM_W-1];
            k1_side_next.s[i].neg_y = dot[SUM_W-1] ^ ab.y[DIFF_W-1] ^ len[SUM_W-1];
            priority if (len == '0 || dot[SUM_W-1])
            begin
                k1_side_next.s[i].mode = MODE_END_A;
            end
            else if (dot > len)
            begin
                k1_side_next.s[i].mode = MODE_END_B;
            end
            else
            begin
                k1_side_next.s[i].mode = MODE_PROJ;
            end
            dmag_next[i] = mag_sum(dot);
            lmag_next[i] = mag_sum(len);
            abx_next[i]  = mag_diff(ab.x);
            aby_next[i]  = mag_diff(ab.y);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k1_side_reg <= k1_side_next;
            k2_side_reg <= k1_side_reg;
            k3_side_reg <= k2_side_reg;
            dly_reg[0]  <= k3_side_reg;
            for (int j = 1; j < QUO_W; j++)
            begin
                dly_reg[j] <= dly_reg[j-1];
            end
            k4_side_reg <= dly_reg[QUO_W-1];
            k5_side_reg <= k4_side_reg;
            for (int i = 0; i < SLOTS; i++)
            begin
                k1_dmag_reg[i] <= dmag_next[i];
                k1_lmag_reg[i] <= lmag_next[i];
                k1_abx_reg[i]  <= abx_next[i];
                k1_aby_reg[i]  <= aby_next[i];

                k2_plx_reg[i]  <= k1_dmag_reg[i][HALF_W-1:0] * k1_abx_reg[i];
                k2_phx_reg[i]  <= k1_dmag_reg[i][SUM_W-1:HALF_W] * k1_abx_reg[i];
                k2_ply_reg[i]  <= k1_dmag_reg[i][HALF_W-1:0] * k1_aby_reg[i];
                k2_phy_reg[i]  <= k1_dmag_reg[i][SUM_W-1:HALF_W] * k1_aby_reg[i];
                k2_lmag_reg[i] <= k1_lmag_reg[i];

                k3_nx_reg[i] <= (((NUM_W'(k2_phx_reg[i]) << HALF_W) + NUM_W'(k2_plx_reg[i])) << 1)
                              + NUM_W'(k2_lmag_reg[i]);
                k3_ny_reg[i] <= (((NUM_W'(k2_phy_reg[i]) << HALF_W) + NUM_W'(k2_ply_reg[i])) << 1)
                              + NUM_W'(k2_lmag_reg[i]);
                k3_d_reg[i]  <= {k2_lmag_reg[i], 1'b0};

                k4_vx_reg[i]  <= vx_next[i];
                k4_vy_reg[i]  <= vy_next[i];
                k5_sqx_reg[i] <= k4_vx_reg[i] * k4_vx_reg[i];
                k5_sqy_reg[i] <= k4_vy_reg[i] * k4_vy_reg[i];
                k6_dist_reg[i] <= dist_next[i];
            end
            k4_cx_reg    <= cx_next;
            k4_cy_reg    <= cy_next;
            k5_cx_reg    <= k4_cx_reg;
            k5_cy_reg    <= k4_cy_reg;
            k6_cx_reg    <= k5_cx_reg;
            k6_cy_reg    <= k5_cy_reg;
            k6_cross_reg <= k5_side_reg.crossing;
            k7_m01_reg   <= (k6_dist_reg[1] < k6_dist_reg[0]) ? k6_dist_reg[1] : k6_dist_reg[0];
            k7_m23_reg   <= (k6_dist_reg[3] < k6_dist_reg[2]) ? k6_dist_reg[3] : k6_dist_reg[2];
            k7_cross_reg <= k6_cross_reg;
            k7_cx_reg    <= k6_cx_reg;
            k7_cy_reg    <= k6_cy_reg;
            rsp_reg      <= rsp_next;
        end
    end

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_div
        spdi_div #(
            .NUM_W (NUM_W),
            .DEN_W (DEN_W),
            .QUO_W (QUO_W)
        ) u_div_x (
            .clk (clk),
            .adv (adv),
            .num (k3_nx_reg[i]),
            .den (k3_d_reg[i]),
            .quo (quo_x[i])
        );

        spdi_div #(
            .NUM_W (NUM_W),
            .DEN_W (DEN_W),
            .QUO_W (QUO_W)
        ) u_div_y (
            .clk (clk),
            .adv (adv),
            .num (k3_ny_reg[i]),
            .den (k3_d_reg[i]),
            .quo (quo_y[i])
        );
    end

    always_comb
    begin
        logic signed [COORD_BITS+1:0] ext_x;
        logic signed [COORD_BITS+1:0] ext_y;
        logic signed [COORD_BITS+1:0] qz_x;
        logic signed [COORD_BITS+1:0] qz_y;
        for (int i = 0; i < SLOTS; i++)
        begin
            logic signed [VEC_W-1:0] qx;
            logic signed [VEC_W-1:0] qy;
            qx = VEC_W'(quo_x[i]);
            qy = VEC_W'(quo_y[i]);
            vx_next[i] = (dly_reg[QUO_W-1].s[i].neg_x ? -qx : qx)
                       - VEC_W'(dly_reg[QUO_W-1].s[i].ap.x);
            vy_next[i] = (dly_reg[QUO_W-1].s[i].neg_y ? -qy : qy)
                       - VEC_W'(dly_reg[QUO_W-1].s[i].ap.y);
        end
        qz_x  = (COORD_BITS + 2)'(quo_x[0]);
        qz_y  = (COORD_BITS + 2)'(quo_y[0]);
        ext_x = (COORD_BITS + 2)'(dly_reg[QUO_W-1].p1_x)
              + (dly_reg[QUO_W-1].s[0].neg_x ? -qz_x : qz_x);
        ext_y = (COORD_BITS + 2)'(dly_reg[QUO_W-1].p1_y)
              + (dly_reg[QUO_W-1].s[0].neg_y ? -qz_y : qz_y);
        cx_next = clamp_coord(ext_x);
        cy_next = clamp_coord(ext_y);
    end

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            logic [SSUM_W-1:0] psum;
            psum = SSUM_W'($unsigned(k5_sqx_reg[i])) + SSUM_W'($unsigned(k5_sqy_reg[i]));
            unique case (k5_side_reg.s[i].mode)
                MODE_END_A: dist_next[i] = sat_dist(SSUM_W'($unsigned(k5_side_reg.s[i].end_a)));
                MODE_END_B: dist_next[i] = sat_dist(SSUM_W'($unsigned(k5_side_reg.s[i].end_b)));
                MODE_PROJ:  dist_next[i] = sat_dist(psum);
                default:    dist_next[i] = DIST_MAX;
            endcase
        end
    end

    always_comb
    begin
        if (k7_cross_reg)
        begin
            rsp_next.dist_squared = '0;
            rsp_next.crossing     = 1'b1;
            rsp_next.cross_x      = k7_cx_reg;
            rsp_next.cross_y      = k7_cy_reg;
        end
        else
        begin
            rsp_next.dist_squared = (k7_m23_reg < k7_m01_reg) ? k7_m23_reg : k7_m01_reg;
            rsp_next.crossing     = 1'b0;
            rsp_next.cross_x      = '0;
            rsp_next.cross_y      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg         <= {v_reg[VLEN-2:0], job_valid};
            rsp_valid_reg <= v_reg[VLEN-1];
        end
    end

endmodule

// ----- sim/segment_pair_distance_intersect_core_checker.sv -----
// Checker that predicts and compares results of the segment pair distance and crossing core
`timescale 1ns / 1ps
module segment_pair_distance_intersect_core_checker
    import spdi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_ready,
    input  spdi_in_t  req,
    input  logic      rsp_valid,
    input  logic      rsp_ready,
    input  spdi_out_t rsp,
    output int        fail_count,
    output int        pending_count
);

    localparam longint CMAX_V = (64'sd1 <<< (COORD_BITS - 1)) - 1;
    localparam longint CMIN_V = -CMAX_V - 1;

    spdi_out_t pending_results[$];

    function automatic logic [DIST_BITS-1:0] sq_dist_sat(longint dx, longint dy);
        logic [127:0] s;
        s = 128'(dx * dx) + 128'(dy * dy);
        return (s > 128'(DIST_MAX)) ? DIST_MAX : s[DIST_BITS-1:0];
    endfunction

    // n / d rounded to nearest, ties away from zero
    function automatic longint div_round(logic signed [127:0] n, logic signed [127:0] d);
        logic [127:0] nm;
        logic [127:0] dm;
        logic [127:0] q;
        logic         neg;
        nm = n < 0 ? -n : n;
        dm = d < 0 ? -d : d;
        neg = (n < 0) != (d < 0);
        q = (2 * nm + dm) / (2 * dm);
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [DIST_BITS-1:0] point_seg_dist(longint px, longint py,
        longint ax, longint ay, longint bx, longint by);
        logic signed [127:0] len2;
        logic signed [127:0] dotp;
        longint abx;
        longint aby;
        longint apx;
        longint apy;
        longint qx;
        longint qy;
        abx = bx - ax;
        aby = by - ay;
        apx = px - ax;
        apy = py - ay;
        len2 = 128'(abx * abx) + 128'(aby * aby);
        if (len2 == 0)
            return sq_dist_sat(apx, apy);
        dotp = 128'(apx * abx) + 128'(apy * aby);
        if (dotp < 0)
            return sq_dist_sat(apx, apy);
        if (dotp > len2)
            return sq_dist_sat(px - bx, py - by);
        qx = ax + div_round(dotp * abx, len2);
        qy = ay + div_round(dotp * aby, len2);
        return sq_dist_sat(qx - px, qy - py);
    endfunction

    function automatic int sgn(logic signed [127:0] v);
        return v == 0 ? 0 : (v < 0 ? -1 : 1);
    endfunction

    function automatic logic signed [127:0] cross2(longint ax, longint ay, longint bx,
        longint by);
        return 128'(ax * by) - 128'(ay * bx);
    endfunction

    function automatic longint clamp_c(longint v);
        return v > CMAX_V ? CMAX_V : (v < CMIN_V ? CMIN_V : v);
    endfunction

    function automatic spdi_out_t predict_segment_pair(spdi_in_t s);
        spdi_out_t o;
        longint p1x;
        longint p1y;
        longint p2x;
        longint p2y;
        longint q1x;
        longint q1y;
        longint q2x;
        longint q2y;
        longint rx;
        longint ry;
        longint sx;
        longint sy;
        int c1;
        int c2;
        int c3;
        int c4;
        logic signed [127:0] den;
        logic signed [127:0] num;
        logic [DIST_BITS-1:0] d;
        logic [DIST_BITS-1:0] e;
        p1x = s.p1_x;
        p1y = s.p1_y;
        p2x = s.p2_x;
        p2y = s.p2_y;
        q1x = s.q1_x;
        q1y = s.q1_y;
        q2x = s.q2_x;
        q2y = s.q2_y;
        rx = p2x - p1x;
        ry = p2y - p1y;
        sx = q2x - q1x;
        sy = q2y - q1y;
        c1 = sgn(cross2(rx, ry, q1x - p1x, q1y - p1y));
        c2 = sgn(cross2(rx, ry, q2x - p1x, q2y - p1y));
        c3 = sgn(cross2(sx, sy, p1x - q1x, p1y - q1y));
        c4 = sgn(cross2(sx, sy, p2x - q1x, p2y - q1y));
        o = '0;
        if (c1 * c2 < 0 && c3 * c4 < 0)
        begin
            den = cross2(rx, ry, sx, sy);
            num = cross2(q1x - p1x, q1y - p1y, sx, sy);
            o.crossing = 1'b1;
            o.cross_x = coord_t'(clamp_c(p1x + div_round(num * rx, den)));
            o.cross_y = coord_t'(clamp_c(p1y + div_round(num * ry, den)));
        end
        else
        begin
            d = point_seg_dist(p1x, p1y, q1x, q1y, q2x, q2y);
            e = point_seg_dist(p2x, p2y, q1x, q1y, q2x, q2y);
            if (e < d) d = e;
            e = point_seg_dist(q1x, q1y, p1x, p1y, p2x, p2y);
            if (e < d) d = e;
            e = point_seg_dist(q2x, q2y, p1x, p1y, p2x, p2y);
            if (e < d) d = e;
            o.dist_squared = d;
        end
        return o;
    endfunction

    assign pending_count = pending_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        spdi_out_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
                pending_results.push_back(predict_segment_pair(req));
            if (rsp_valid && rsp_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with no pending expectation");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp.dist_squared !== want.dist_squared)
                        $error("dist_squared: expected %0d actual %0d",
                            want.dist_squared, rsp.dist_squared);
                    if (rsp.crossing !== want.crossing)
                        $error("crossing: expected %0d actual %0d", want.crossing, rsp.crossing);
                    if (rsp.cross_x !== want.cross_x)
                        $error("cross_x: expected %0d actual %0d", want.cross_x, rsp.cross_x);
                    if (rsp.cross_y !== want.cross_y)
                        $error("cross_y: expected %0d actual %0d", want.cross_y, rsp.cross_y);
                    if (rsp !== want)
                        fail_count <= fail_count + 1;
                end
            end
        end
    end

endmodule

// ----- sim/segment_pair_distance_intersect_core_test.sv -----
// Testbench top for the segment pair distance and crossing core
`timescale 1ns / 1ps
module segment_pair_distance_intersect_core_test;
    import spdi_pkg::*;

    localparam int RANDOM_PAIRS = 1250;
    localparam int DRAIN_CYCLES = 100;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    spdi_in_t  req;
    logic      rsp_valid;
    logic      rsp_ready;
    spdi_out_t rsp;
    int        fail_count;
    int        pending_count;
    bit        hold_off;

    segment_pair_distance_intersect_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    segment_pair_distance_intersect_core_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("** segment_pair_distance_intersect_core: FAILED **");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic coord_t rand_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($signed($urandom_range(0, 4000)) - 2000);
            default: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
        endcase
    endfunction

    function automatic spdi_in_t rand_pair();
        spdi_in_t s;
        int mode;
        int shape;
        mode = $urandom_range(0, 9) < 4 ? 0 : ($urandom_range(0, 19) == 0 ? 2 : 1);
        s.p1_x = rand_coord(mode);
        s.p1_y = rand_coord(mode);
        s.p2_x = rand_coord(mode);
        s.p2_y = rand_coord(mode);
        s.q1_x = rand_coord(mode);
        s.q1_y = rand_coord(mode);
        s.q2_x = rand_coord(mode);
        s.q2_y = rand_coord(mode);
        shape = $urandom_range(0, 9);
        if (shape == 0)
        begin
            s.p2_x = s.p1_x;
            s.p2_y = s.p1_y;
        end
        else if (shape == 1)
        begin
            s.q1_x = s.p2_x;
            s.q1_y = s.p2_y;
        end
        else if (shape == 2)
        begin
            s.q1_y = s.p1_y;
            s.q2_y = s.p1_y;
            s.p2_y = s.p1_y;
        end
        else if (shape == 3)
        begin
            // force a crossing: swap endpoints around a common center
            s.q1_x = s.p1_x;
            s.q2_x = s.p2_x;
            s.q1_y = s.p2_y;
            s.q2_y = s.p1_y;
        end
        return s;
    endfunction

    task automatic send_pair(spdi_in_t s);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            req_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= s;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int hold;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                rsp_ready <= 1'b0;
                for (hold = 0; hold < 150; hold++) @(negedge clk);
                hold_off = 1'b0;
            end
            rsp_ready <= ($urandom_range(0, 2) != 0) || (gap_len() == 0);
        end
    end

    initial
    begin
        spdi_in_t s;
        int wait_cycles;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        hold_off = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        s = '0;
        send_pair(s);
        s = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000,
              24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000};
        send_pair(s);
        s = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
              24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000};
        send_pair(s);
        s = '{-24'sd1000, 24'sd0, 24'sd1000, 24'sd0, 24'sd0, -24'sd1000, 24'sd0, 24'sd1001};
        send_pair(s);
        s = '{24'sd0, 24'sd0, 24'sd1000, 24'sd0, 24'sd1000, 24'sd0, 24'sd2000, 24'sd500};
        send_pair(s);
        s = '{24'sd0, 24'sd0, 24'sd1000, 24'sd0, 24'sd500, 24'sd0, 24'sd2000, 24'sd0};
        send_pair(s);
        s = '{24'sd0, 24'sd0, 24'sd1000, 24'sd0, 24'sd500, 24'sd0, 24'sd500, 24'sd300};
        send_pair(s);
        s = '{24'sd0, 24'sd0, 24'sd1000, 24'sd0, 24'sd0, 24'sd7, 24'sd1000, 24'sd7};
        send_pair(s);
        s = '{24'sd5, 24'sd5, 24'sd5, 24'sd5, 24'sd0, 24'sd0, 24'sd3, 24'sd7};
        send_pair(s);
        s = '{24'sd1, 24'sd1, 24'sd1, 24'sd1, 24'sd4, 24'sd5, 24'sd4, 24'sd5};
        send_pair(s);
        s = '{24'sd0, 24'sd0, 24'sd3, 24'sd1, 24'sd1, 24'sd0, 24'sd0, 24'sd1};
        send_pair(s);
        s = '{24'sh800000, 24'sd0, 24'sh7FFFFF, 24'sd1, 24'sd0, 24'sh800000, 24'sd1,
              24'sh7FFFFF};
        send_pair(s);
        s = '{24'sd0, 24'sd0, 24'sd10, 24'sd0, 24'sd20, 24'sd0, 24'sd30, 24'sd0};
        send_pair(s);
        s = '{-24'sd1, -24'sd1, 24'sd1, 24'sd1, -24'sd1, 24'sd1, 24'sd1, -24'sd1};
        send_pair(s);

        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            if (i == RANDOM_PAIRS / 2)
                hold_off = 1'b1;
            send_pair(rand_pair());
        end
        req_valid <= 1'b0;

        wait_cycles = 0;
        while (pending_count != 0 && wait_cycles < 200000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("** segment_pair_distance_intersect_core: PASSED **");
        else
            $display("** segment_pair_distance_intersect_core: FAILED **");
        $finish;
    end

endmodule
